// ----- sv/nbk_pkg.sv -----
// ----------------------------------------------------------------------------
// nbk_pkg
// Shared constants, codes and controller/datapath types of the neighbor
// bucket kick hash flow counter.
// ----------------------------------------------------------------------------
package nbk_pkg;

  localparam int unsigned BUCKETS_DEF    = 2048;
  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LIMIT   = 2'd2;

  localparam logic [11:0] RST_BUCKET_COUNT = 12'd2048;
  localparam logic [2:0]  RST_SLOTS_IN_USE = 3'd2;
  localparam logic [5:0]  RST_KICK_LIMIT   = 6'd6;

  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_KICKED   = 3'd2;
  localparam logic [2:0] ST_LIMIT    = 3'd3;
  localparam logic [2:0] ST_NOVICTIM = 3'd4;
  localparam logic [2:0] ST_QHIT     = 3'd5;
  localparam logic [2:0] ST_QMISS    = 3'd6;

  localparam logic [1:0] OFF_ZERO  = 2'b00;
  localparam logic [1:0] OFF_PLUS  = 2'b01;
  localparam logic [1:0] OFF_MINUS = 2'b11;

  localparam logic [1:0] CAND_HOME = 2'd0;
  localparam logic [1:0] CAND_UP   = 2'd1;
  localparam logic [1:0] CAND_DOWN = 2'd2;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_CRD, S_CEV, S_KRD, S_KEV, S_FIN
  } state_e;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       rd_cand;
    logic       cand_next;
    logic       apply_ins;
    logic       q_hit;
    logic       kick_init;
    logic       kick_rd;
    logic       kick_place;
    logic       kick_swap;
    logic       kick_phase2;
    logic       kick_drop;
    logic       set_code;
    logic [2:0] code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic func;
    logic hit_any;
    logic hit_match;
    logic qhit;
    logic cand_last;
    logic kfree;
    logic kover;
    logic kvictim;
    logic first_phase;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/nbk_div.sv -----
// ----------------------------------------------------------------------------
// nbk_div
// Restoring remainder unit, one key bit per cycle: key mod bucket count.
// ----------------------------------------------------------------------------
module nbk_div #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned NBW      = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KEY_BITS-1:0] dividend_i,
  input  logic [NBW-1:0]      divisor_i,
  output logic                done_o,
  output logic [NBW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(KEY_BITS + 1);

  logic                busy_q;
  logic [CW-1:0]       cnt_q;
  logic [KEY_BITS-1:0] quo_q;
  logic [NBW-1:0]      rem_q;
  logic [NBW:0]        sh;
  logic [NBW-1:0]      rem_d;

  always_comb begin
    sh = {rem_q, quo_q[KEY_BITS-1]};
    if (sh >= {1'b0, divisor_i}) begin
      rem_d = NBW'(sh - {1'b0, divisor_i});
    end else begin
      rem_d = NBW'(sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(KEY_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/nbk_ctrl.sv -----
// ----------------------------------------------------------------------------
// nbk_ctrl
// Sequencer: clearing pass, candidate scan, kick chain, result hand-off.
// ----------------------------------------------------------------------------
module nbk_ctrl import nbk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        cmd_o.rd_cand = 1'b1;
        state_d       = S_CEV;
      end
      S_CEV: begin
        if (sts_i.func) begin
          if (sts_i.qhit) begin
            cmd_o.q_hit    = 1'b1;
            cmd_o.set_code = 1'b1;
            cmd_o.code     = ST_QHIT;
            state_d        = S_FIN;
          end else if (sts_i.cand_last) begin
            cmd_o.set_code = 1'b1;
            cmd_o.code     = ST_QMISS;
            state_d        = S_FIN;
          end else begin
            cmd_o.cand_next = 1'b1;
            state_d         = S_CRD;
          end
        end else if (sts_i.hit_any) begin
          cmd_o.apply_ins = 1'b1;
          cmd_o.set_code  = 1'b1;
          cmd_o.code      = sts_i.hit_match ? ST_COUNTED : ST_STORED;
          state_d         = S_FIN;
        end else if (sts_i.cand_last) begin
          cmd_o.kick_init = 1'b1;
          state_d         = S_KRD;
        end else begin
          cmd_o.cand_next = 1'b1;
          state_d         = S_CRD;
        end
      end
      S_KRD: begin
        cmd_o.kick_rd = 1'b1;
        state_d       = S_KEV;
      end
      S_KEV: begin
        if (sts_i.kfree) begin
          cmd_o.kick_place = 1'b1;
          cmd_o.set_code   = 1'b1;
          cmd_o.code       = ST_KICKED;
          state_d          = S_FIN;
        end else if (sts_i.kover) begin
          cmd_o.kick_drop = 1'b1;
          cmd_o.set_code  = 1'b1;
          cmd_o.code      = ST_LIMIT;
          state_d         = S_FIN;
        end else if (sts_i.kvictim) begin
          cmd_o.kick_swap = 1'b1;
          state_d         = S_KRD;
        end else if (sts_i.first_phase) begin
          cmd_o.kick_phase2 = 1'b1;
          state_d           = S_KRD;
        end else begin
          cmd_o.kick_drop = 1'b1;
          cmd_o.set_code  = 1'b1;
          cmd_o.code      = ST_NOVICTIM;
          state_d         = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/nbk_dp.sv -----
// ----------------------------------------------------------------------------
// nbk_dp
// Datapath: configuration, bucket table, slot search, kick registers and
// the result register.
// ----------------------------------------------------------------------------
module nbk_dp import nbk_pkg::*; #(
  parameter int unsigned BUCKETS    = BUCKETS_DEF,
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  func_i,
  input  logic [KEY_BITS-1:0]   flow_key_i,
  input  logic                  kick_direction_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [2:0]            status_o,
  output logic [COUNT_BITS-1:0] flow_count_o,
  output logic signed [1:0]     home_offset_o,
  output logic [KEY_BITS-1:0]   dropped_key_o
);

  localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NBW = $clog2(BUCKETS + 1);
  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NSW = $clog2(SLOTS + 1);

  typedef logic [SLOTS-1:0][KEY_BITS-1:0]   krow_t;
  typedef logic [SLOTS-1:0][COUNT_BITS-1:0] crow_t;
  typedef logic [SLOTS-1:0][1:0]            orow_t;

  logic [11:0] bc_q;
  logic [2:0]  su_q;
  logic [5:0]  kl_q;
  logic [NBW-1:0] nb;
  logic [NSW-1:0] ns;

  logic                func_q, dir_q;
  logic [KEY_BITS-1:0] key_q;
  logic                div_done;
  logic [NBW-1:0]      rem;
  logic [BW-1:0]       cand0, cand_row, kick_row;
  logic [1:0]          sel_q, cand_off;
  logic [BW-1:0]       cur_row_q, clr_cnt_q;

  krow_t key_mem [BUCKETS];
  crow_t cnt_mem [BUCKETS];
  orow_t off_mem [BUCKETS];
  krow_t rk_q, wk;
  crow_t rc_q, wc;
  orow_t ro_q, wo;
  logic          rd_en, wr_en;
  logic [BW-1:0] rd_addr, wr_addr;

  logic [KEY_BITS-1:0]   ck_q;
  logic [COUNT_BITS-1:0] cc_q;
  logic [1:0]            co_q;
  logic                  carry_new_q, first_q;
  logic [BW-1:0]         idx_q;
  logic [6:0]            steps_q;
  logic [1:0]            d_off, want, co_next;

  logic          hit_any, hit_match, qhit, kfree, kvictim;
  logic [SW-1:0] hit_j, q_j, f_j, v_j;
  logic [COUNT_BITS-1:0] inc_cnt;

  logic [COUNT_BITS-1:0] res_cnt_q;
  logic [1:0]            res_off_q;
  logic [KEY_BITS-1:0]   res_drop_q;
  logic [2:0]            res_code_q;

  function automatic logic [BW-1:0] bk_up(input logic [BW-1:0] b, input logic [NBW-1:0] n);
    logic [NBW:0] s;
    s = (NBW+1)'(b) + (NBW+1)'(1);
    return (s >= {1'b0, n}) ? '0 : BW'(s);
  endfunction

  function automatic logic [BW-1:0] bk_down(input logic [BW-1:0] b, input logic [NBW-1:0] n);
    return (b == '0) ? BW'(n - NBW'(1)) : b - BW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= RST_BUCKET_COUNT;
      su_q <= RST_SLOTS_IN_USE;
      kl_q <= RST_KICK_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUCKET_COUNT: bc_q <= cfg_data_i;
        CFG_SLOTS_IN_USE: su_q <= cfg_data_i[2:0];
        CFG_KICK_LIMIT:   kl_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bc_q == '0) begin
      nb = NBW'(1);
    end else if (32'(bc_q) > BUCKETS) begin
      nb = NBW'(BUCKETS);
    end else begin
      nb = NBW'(bc_q);
    end
    if (su_q == '0) begin
      ns = NSW'(1);
    end else if (32'(su_q) > SLOTS) begin
      ns = NSW'(SLOTS);
    end else begin
      ns = NSW'(su_q);
    end
  end

  nbk_div #(
    .KEY_BITS (KEY_BITS),
    .NBW      (NBW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (flow_key_i),
    .divisor_i  (nb),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign cand0 = BW'(rem);
  assign d_off = dir_q ? OFF_PLUS : OFF_MINUS;
  assign want  = first_q ? (dir_q ? OFF_MINUS : OFF_PLUS) : OFF_ZERO;
  assign co_next  = co_q + d_off;
  assign kick_row = dir_q ? bk_down(idx_q, nb) : bk_up(idx_q, nb);

  always_comb begin
    case (sel_q)
      CAND_HOME: begin
        cand_row = cand0;
        cand_off = OFF_ZERO;
      end
      CAND_UP: begin
        cand_row = bk_up(cand0, nb);
        cand_off = OFF_MINUS;
      end
      default: begin
        cand_row = bk_down(cand0, nb);
        cand_off = OFF_PLUS;
      end
    endcase
  end

  // lowest enabled slot wins each search
  always_comb begin
    logic en, used, eq;
    hit_any = 1'b0; hit_match = 1'b0; hit_j = '0;
    qhit    = 1'b0; q_j = '0;
    kfree   = 1'b0; f_j = '0;
    kvictim = 1'b0; v_j = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      en   = NSW'(j) < ns;
      used = rc_q[j] != '0;
      eq   = used && (rk_q[j] == key_q);
      if (en && (eq || !used)) begin
        hit_any = 1'b1; hit_match = eq; hit_j = SW'(j);
      end
      if (en && eq) begin
        qhit = 1'b1; q_j = SW'(j);
      end
      if (en && !used) begin
        kfree = 1'b1; f_j = SW'(j);
      end
      if (en && (ro_q[j] == want)) begin
        kvictim = 1'b1; v_j = SW'(j);
      end
    end
  end

  assign inc_cnt = (rc_q[hit_j] == '1) ? rc_q[hit_j] : rc_q[hit_j] + COUNT_BITS'(1);

  always_comb begin
    rd_en   = cmd_i.rd_cand || cmd_i.kick_rd;
    rd_addr = cmd_i.kick_rd ? kick_row : cand_row;
    wr_en   = 1'b0;
    wr_addr = cur_row_q;
    wk      = rk_q;
    wc      = rc_q;
    wo      = ro_q;
    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wk      = '0;
      wc      = '0;
      wo      = '0;
    end else if (cmd_i.apply_ins) begin
      wr_en = 1'b1;
      if (hit_match) begin
        wc[hit_j] = inc_cnt;
      end else begin
        wk[hit_j] = key_q;
        wc[hit_j] = COUNT_BITS'(1);
        wo[hit_j] = cand_off;
      end
    end else if (cmd_i.kick_place) begin
      wr_en   = 1'b1;
      wk[f_j] = ck_q;
      wc[f_j] = cc_q;
      wo[f_j] = co_next;
    end else if (cmd_i.kick_swap) begin
      wr_en   = 1'b1;
      wk[v_j] = ck_q;
      wc[v_j] = cc_q;
      wo[v_j] = co_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wk;
      cnt_mem[wr_addr] <= wc;
      off_mem[wr_addr] <= wo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rk_q <= key_mem[rd_addr];
      rc_q <= cnt_mem[rd_addr];
      ro_q <= off_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      sel_q       <= CAND_HOME;
      steps_q     <= '0;
      first_q     <= 1'b1;
      carry_new_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + BW'(1);
      end
      if (cmd_i.load) begin
        sel_q <= CAND_HOME;
      end else if (cmd_i.cand_next) begin
        sel_q <= sel_q + 2'd1;
      end
      if (cmd_i.kick_init) begin
        steps_q     <= '0;
        first_q     <= 1'b1;
        carry_new_q <= 1'b1;
      end else begin
        if (cmd_i.kick_rd) begin
          steps_q <= steps_q + 7'd1;
        end
        if (cmd_i.kick_phase2) begin
          first_q <= 1'b0;
        end
        if (cmd_i.kick_swap) begin
          carry_new_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_i;
      key_q      <= flow_key_i;
      dir_q      <= kick_direction_i;
      res_cnt_q  <= '0;
      res_off_q  <= OFF_ZERO;
      res_drop_q <= '0;
    end
    if (cmd_i.rd_cand || cmd_i.kick_rd) begin
      cur_row_q <= rd_addr;
    end
    if (cmd_i.kick_init) begin
      ck_q  <= key_q;
      cc_q  <= COUNT_BITS'(1);
      co_q  <= OFF_ZERO;
      idx_q <= cand0;
    end
    if (cmd_i.kick_swap) begin
      ck_q  <= rk_q[v_j];
      cc_q  <= rc_q[v_j];
      co_q  <= ro_q[v_j];
      idx_q <= cur_row_q;
    end
    if (cmd_i.apply_ins) begin
      res_cnt_q <= hit_match ? inc_cnt : COUNT_BITS'(1);
      res_off_q <= hit_match ? ro_q[hit_j] : cand_off;
    end
    if (cmd_i.q_hit) begin
      res_cnt_q <= rc_q[q_j];
      res_off_q <= ro_q[q_j];
    end
    if ((cmd_i.kick_place || cmd_i.kick_swap) && carry_new_q) begin
      res_cnt_q <= cc_q;
      res_off_q <= co_next;
    end
    if (cmd_i.kick_drop) begin
      res_drop_q <= ck_q;
    end
    if (cmd_i.set_code) begin
      res_code_q <= cmd_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= res_code_q;
      flow_count_o  <= res_cnt_q;
      home_offset_o <= res_off_q;
      dropped_key_o <= res_drop_q;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.clr_last    = clr_cnt_q == BW'(BUCKETS - 1);
    sts_o.div_done    = div_done;
    sts_o.func        = func_q;
    sts_o.hit_any     = hit_any;
    sts_o.hit_match   = hit_match;
    sts_o.qhit        = qhit;
    sts_o.cand_last   = sel_q == CAND_DOWN;
    sts_o.kfree       = kfree;
    sts_o.kover       = steps_q > {1'b0, kl_q};
    sts_o.kvictim     = kvictim;
    sts_o.first_phase = first_q;
    sts_o.out_free    = !out_valid_o || !out_stall_i;
  end

endmodule

// ----- sv/neighbor_bucket_kick_hash_counter.sv -----
// ----------------------------------------------------------------------------
// neighbor_bucket_kick_hash_counter
// Flow counter over a bucketed table with neighbor placement and kicks.
// ----------------------------------------------------------------------------
// Usage: an input beat (func_i, flow_key_i, kick_direction_i) is taken when
// in_valid_i is high and in_stall_o low; every beat yields exactly one
// result beat on out_valid_o/out_stall_i. Configuration must be written
// through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle; the
// block itself does not enforce this. Per item: a load, the serial remainder
// unit for the home bucket, a read and an evaluation of each candidate
// bucket (up to 3), a row read and an evaluation per kick step (a step that
// places or swaps also writes the row), and the result hand-off. The table
// read is registered, so each step reads a row before it evaluates it.
// One item is processed at a time; a finished result sits in the output
// register, so a stalled receiver holds only the next hand-off.
// After reset the table is cleared one bucket row per cycle, all BUCKETS
// rows, during which in_stall_o stays high.
// ----------------------------------------------------------------------------
module neighbor_bucket_kick_hash_counter import nbk_pkg::*; #(
  parameter int unsigned BUCKETS    = BUCKETS_DEF,
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [KEY_BITS-1:0]   flow_key_i,
  input  logic                  kick_direction_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [COUNT_BITS-1:0] flow_count_o,
  output logic signed [1:0]     home_offset_o,
  output logic [KEY_BITS-1:0]   dropped_key_o
);

  cmd_t cmd;
  sts_t sts;

  nbk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nbk_dp #(
    .BUCKETS    (BUCKETS),
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .flow_key_i       (flow_key_i),
    .kick_direction_i (kick_direction_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .flow_count_o     (flow_count_o),
    .home_offset_o    (home_offset_o),
    .dropped_key_o    (dropped_key_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new beat taken while an item is in flight");

  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_QMISS |-> flow_count_o == '0 && home_offset_o == 2'sd0)
    else $error("query miss carries data");

  a_stored_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_COUNTED || status_o == ST_STORED ||
                    status_o == ST_QHIT) |-> flow_count_o != '0)
    else $error("stored key reported with zero count");

  a_drop_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_LIMIT && status_o != ST_NOVICTIM
      |-> dropped_key_o == '0)
    else $error("dropped key set without a drop");

endmodule

// ----- dv/nbk_flow_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbk_flow_checker
// Watches the config port and both beat channels of the flow counter, keeps
// its own copy of the bucket table, predicts one result per input beat and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nbk_flow_checker import nbk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 func_i,
  input  logic [31:0]          flow_key_i,
  input  logic                 kick_direction_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [2:0]           status_i,
  input  logic [31:0]          flow_count_i,
  input  logic signed [1:0]    home_offset_i,
  input  logic [31:0]          dropped_key_i,
  output int                   fails_o,
  output int                   in_beats_o,
  output int                   pending_o
);

  localparam int unsigned NBK = BUCKETS_DEF;
  localparam int unsigned NSL = SLOTS_DEF;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] count;
    logic [1:0]  offset;
    logic [31:0] dropped;
  } flow_result_t;

  logic [31:0] tab_key [NBK*NSL];
  logic [31:0] tab_cnt [NBK*NSL];
  int          tab_off [NBK*NSL];
  logic [11:0] bucket_cnt;
  logic [2:0]  slot_cnt;
  logic [5:0]  kick_lim;
  flow_result_t result_q[$];
  int n_out;

  function automatic int unsigned up_b(int unsigned b, int unsigned nb);
    return (b + 1 >= nb) ? 0 : b + 1;
  endfunction

  function automatic int unsigned down_b(int unsigned b, int unsigned nb);
    return (b == 0) ? nb - 1 : b - 1;
  endfunction

  task automatic place(int unsigned p, logic [31:0] k, logic [31:0] c, int o);
    tab_key[p] = k;
    tab_cnt[p] = c;
    tab_off[p] = o;
  endtask

  task automatic predict_flow(input logic fn, input logic [31:0] key, input logic dir,
                              output flow_result_t r);
    int unsigned nb, ns, p, row, hit, idx, steps;
    int unsigned cand[3];
    int cand_off[3];
    int d, want, co, vo, off;
    logic [31:0] ck, cc, vk, vc;
    bit done, carrying, first;
    nb = (bucket_cnt == 0) ? 1 : (bucket_cnt > NBK) ? NBK : bucket_cnt;
    ns = (slot_cnt == 0) ? 1 : (slot_cnt > NSL) ? NSL : slot_cnt;
    d = dir ? 1 : -1;
    cand[0] = key % nb;
    cand[1] = up_b(cand[0], nb);
    cand[2] = down_b(cand[0], nb);
    cand_off = '{0, -1, 1};
    r.status = ST_QMISS;
    r.count = '0;
    r.dropped = '0;
    off = 0;
    done = 0;
    for (int i = 0; i < 3 && !done; i++) begin
      for (int j = 0; j < ns; j++) begin
        p = cand[i] * NSL + j;
        if (tab_cnt[p] != 0 && tab_key[p] == key) begin
          if (fn) begin
            r.status = ST_QHIT;
          end else begin
            if (tab_cnt[p] != '1) tab_cnt[p]++;
            r.status = ST_COUNTED;
          end
          r.count = tab_cnt[p];
          off = tab_off[p];
          done = 1;
          break;
        end
        if (!fn && tab_cnt[p] == 0) begin
          place(p, key, 1, cand_off[i]);
          r.status = ST_STORED;
          r.count = 1;
          off = cand_off[i];
          done = 1;
          break;
        end
      end
    end
    if (!fn && !done) begin
      ck = key;
      cc = 1;
      co = 0;
      carrying = 1;
      first = 1;
      idx = cand[0];
      steps = 0;
      forever begin
        steps = (steps + 1) & 7'h7f;
        row = (d < 0) ? up_b(idx, nb) : down_b(idx, nb);
        hit = ns;
        for (int j = 0; j < ns; j++) begin
          if (tab_cnt[row*NSL+j] == 0) begin
            hit = j;
            break;
          end
        end
        if (hit < ns) begin
          place(row*NSL+hit, ck, cc, co + d);
          if (carrying) begin
            r.count = cc;
            off = co + d;
          end
          r.status = ST_KICKED;
          break;
        end
        if (steps > kick_lim) begin
          r.status = ST_LIMIT;
          r.dropped = ck;
          break;
        end
        want = first ? -d : 0;
        for (int j = 0; j < ns; j++) begin
          if (tab_off[row*NSL+j] == want) begin
            hit = j;
            break;
          end
        end
        if (hit >= ns) begin
          if (first) begin
            first = 0;
            continue;
          end
          r.status = ST_NOVICTIM;
          r.dropped = ck;
          break;
        end
        p = row * NSL + hit;
        vk = tab_key[p];
        vc = tab_cnt[p];
        vo = tab_off[p];
        place(p, ck, cc, co + d);
        if (carrying) begin
          r.count = cc;
          off = co + d;
          carrying = 0;
        end
        ck = vk;
        cc = vc;
        co = vo;
        idx = row;
      end
    end
    r.offset = off[1:0];
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch beat %0d %s: got %0h want %0h", n_out, what, got, want);
    fails_o++;
  endtask

  initial begin
    for (int i = 0; i < NBK*NSL; i++) place(i, '0, '0, 0);
    bucket_cnt = RST_BUCKET_COUNT;
    slot_cnt = RST_SLOTS_IN_USE;
    kick_lim = RST_KICK_LIMIT;
    fails_o = 0;
    in_beats_o = 0;
    pending_o = 0;
    n_out = 0;
  end

  always @(posedge clk_i) begin
    flow_result_t r, e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BUCKET_COUNT: bucket_cnt = cfg_data_i[11:0];
          CFG_SLOTS_IN_USE: slot_cnt = cfg_data_i[2:0];
          CFG_KICK_LIMIT:   kick_lim = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report("unexpected beat", 32'(status_i), '0);
        end else begin
          e = result_q.pop_front();
          if (status_i !== e.status) report("status", 32'(status_i), 32'(e.status));
          if (flow_count_i !== e.count) report("flow_count", flow_count_i, e.count);
          if (home_offset_i !== e.offset) begin
            report("home_offset", 32'(home_offset_i), 32'(e.offset));
          end
          if (dropped_key_i !== e.dropped) report("dropped_key", dropped_key_i, e.dropped);
        end
        n_out++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_flow(func_i, flow_key_i, kick_direction_i, r);
        result_q = {result_q, r};
        in_beats_o++;
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives inserts and queries into the flow counter over several table
// settings with colliding key pools, idles both channels, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top import nbk_pkg::*; ();

  localparam int LIMIT = 1500000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic func = 0;
  logic [31:0] flow_key = '0;
  logic kick_dir = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [31:0] flow_count;
  logic signed [1:0] home_offset;
  logic [31:0] dropped_key;
  int fails, in_beats, pending;
  int cycles = 0;
  int mode = 0;
  int sent = 0;
  logic [31:0] key_pool[16];

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  neighbor_bucket_kick_hash_counter dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .flow_key_i(flow_key), .kick_direction_i(kick_dir),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .flow_count_o(flow_count),
    .home_offset_o(home_offset), .dropped_key_o(dropped_key)
  );

  nbk_flow_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .flow_key_i(flow_key), .kick_direction_i(kick_dir),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .flow_count_i(flow_count),
    .home_offset_i(home_offset), .dropped_key_i(dropped_key),
    .fails_o(fails), .in_beats_o(in_beats), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    case (mode)
      0: out_stall <= ($urandom_range(0, 99) < 50);
      1: out_stall <= ($urandom_range(0, 99) < 17);
      default: out_stall <= 1'b0;
    endcase
  end

  task automatic send_beat(logic fn, logic [31:0] key, logic dir);
    int n0;
    int gap_pct;
    gap_pct = (mode == 0) ? 17 : (mode == 1) ? 50 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    n0 = in_beats;
    in_valid <= 1'b1;
    func <= fn;
    flow_key <= key;
    kick_dir <= dir;
    do @(negedge clk_i); while (in_beats == n0);
    sent++;
    mode = (sent < 140) ? 0 : (sent < 280) ? 1 : 2;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_table(logic [11:0] nb, logic [2:0] ns, logic [5:0] kl);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BUCKET_COUNT;
    cfg_data <= nb;
    @(negedge clk_i);
    cfg_idx <= CFG_SLOTS_IN_USE;
    cfg_data <= CFG_W'(ns);
    @(negedge clk_i);
    cfg_idx <= CFG_KICK_LIMIT;
    cfg_data <= CFG_W'(kl);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int n, int unsigned span);
    logic [31:0] k;
    int sel;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom_range(0, span);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) k = key_pool[$urandom_range(0, 15)];
      else if (sel < 90) k = $urandom_range(0, 63);
      else k = $urandom;
      send_beat($urandom_range(0, 99) < 25, k, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // default table: extremes of the key, a repeated insert, query hit and miss
    send_beat(1'b0, 32'h0, 1'b0);
    send_beat(1'b0, 32'hffff_ffff, 1'b1);
    send_beat(1'b0, 32'h0, 1'b0);
    send_beat(1'b1, 32'h0, 1'b0);
    send_beat(1'b1, 32'hffff_ffff, 1'b1);
    send_beat(1'b1, 32'h1234_5678, 1'b0);
    drain();
    // single bucket, single slot, no kicks allowed
    set_table(12'd1, 3'd1, 6'd0);
    send_beat(1'b0, 32'd5, 1'b0);
    send_beat(1'b0, 32'd6, 1'b0);
    send_beat(1'b0, 32'd7, 1'b1);
    send_beat(1'b1, 32'd5, 1'b1);
    drain();
    // zero settings saturate low
    set_table(12'd0, 3'd0, 6'd1);
    send_beat(1'b0, 32'd8, 1'b1);
    send_beat(1'b0, 32'd9, 1'b0);
    send_beat(1'b1, 32'd9, 1'b0);
    drain();
    // three buckets, deep chains
    set_table(12'd3, 3'd1, 6'd63);
    for (int i = 0; i < 8; i++) send_beat(1'b0, 32'd3 * i + (i % 3), i[0]);
    send_beat(1'b1, 32'd0, 1'b0);
    drain();
    set_table(12'd4, 3'd1, 6'd3);
    random_phase(60, 40);
    set_table(12'd2, 3'd2, 6'd0);
    random_phase(55, 30);
    set_table(12'd1, 3'd4, 6'd63);
    random_phase(55, 30);
    set_table(12'd0, 3'd0, 6'd5);
    random_phase(50, 20);
    set_table(12'd8, 3'd4, 6'd6);
    random_phase(60, 120);
    set_table(12'd3, 3'd2, 6'd2);
    random_phase(60, 40);
    set_table(12'hfff, 3'd7, 6'd63);
    random_phase(60, 32'hffff_ffff);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
